>>> src/rth_pkg.sv
package rth_pkg;

	localparam int PIX_W     = 8;
	localparam int DIV_STEPS = 8;
	localparam int SAT_NW    = 16;
	localparam int HUE_NW    = 19;
	localparam int HUE_DW    = 11;
	localparam int HUE_MW    = 12;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [SAT_NW-1:0] num_sat;
		logic [PIX_W-1:0]  den_sat;
		logic [HUE_NW-1:0] num_hue;
		logic [HUE_DW-1:0] den_hue;
		logic [PIX_W-1:0]  bright;
	} div_req_t;

	typedef struct packed {
		logic [SAT_NW-1:0] rem_sat;
		logic [PIX_W-1:0]  den_sat;
		logic [PIX_W-1:0]  q_sat;
		logic [HUE_NW-1:0] rem_hue;
		logic [HUE_DW-1:0] den_hue;
		logic [PIX_W-1:0]  q_hue;
		logic [PIX_W-1:0]  bright;
	} div_stage_t;

	typedef struct packed {
		logic [PIX_W-1:0] hue;
		logic [PIX_W-1:0] saturation;
		logic [PIX_W-1:0] brightness;
	} hsv_t;

endpackage

>>> src/rth_if.sv
interface rth_pix_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;

	modport source (output valid, blue, green, red, input ready);
	modport sink (input valid, blue, green, red, output ready);
endinterface

interface rth_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

>>> src/rth_div.sv
module rth_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rth_pkg::div_req_t req,
	output logic              res_valid,
	input  logic              res_ready,
	output rth_pkg::hsv_t     res
);
	import rth_pkg::*;

	div_stage_t st_s  [DIV_STEPS];
	logic       vld_s [DIV_STEPS];
	logic       adv   [DIV_STEPS+1];

	assign adv[DIV_STEPS] = res_ready;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int Sh = DIV_STEPS - 1 - k;

		div_stage_t        src;
		logic              src_vld;
		div_stage_t        nxt;
		logic [SAT_NW-1:0] dsh_sat;
		logic [HUE_NW-1:0] dsh_hue;
		logic              ge_sat;
		logic              ge_hue;

		if (k == 0) begin : g_first
			assign src_vld     = req_valid;
			assign src.rem_sat = req.num_sat;
			assign src.den_sat = req.den_sat;
			assign src.q_sat   = '0;
			assign src.rem_hue = req.num_hue;
			assign src.den_hue = req.den_hue;
			assign src.q_hue   = '0;
			assign src.bright  = req.bright;
		end else begin : g_next
			assign src_vld = vld_s[k-1];
			assign src     = st_s[k-1];
		end

		assign adv[k] = !vld_s[k] || adv[k+1];

		always_comb begin
			dsh_sat = SAT_NW'(src.den_sat) << Sh;
			dsh_hue = HUE_NW'(src.den_hue) << Sh;
			ge_sat  = src.rem_sat >= dsh_sat;
			ge_hue  = src.rem_hue >= dsh_hue;
			nxt         = src;
			nxt.rem_sat = ge_sat ? src.rem_sat - dsh_sat : src.rem_sat;
			nxt.rem_hue = ge_hue ? src.rem_hue - dsh_hue : src.rem_hue;
			nxt.q_sat   = {src.q_sat[PIX_W-2:0], ge_sat};
			nxt.q_hue   = {src.q_hue[PIX_W-2:0], ge_hue};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				st_s[k] <= nxt;
			end
		end
	end

	assign req_ready      = adv[0];
	assign res_valid      = vld_s[DIV_STEPS-1];
	assign res.hue        = st_s[DIV_STEPS-1].q_hue;
	assign res.saturation = st_s[DIV_STEPS-1].q_sat;
	assign res.brightness = st_s[DIV_STEPS-1].bright;

endmodule

>>> src/rgb_to_hsv_8bit_top.sv
// order: input beat -> stage 1 -> stage 2 -> divider stages -> result beat
// throughput: one pixel per cycle when not stalled; two front stages, then
// one quotient bit per stage for both divides through eight divider stages
// reset: arst_n clears every valid bit at once, no item survives reset
module rgb_to_hsv_8bit_top (
	input logic          clk,
	input logic          arst_n,
	rth_pix_in_if.sink   pix_in,
	rth_pix_out_if.source pix_out
);
	import rth_pkg::*;

	// stage 1: max, min, range and sector
	logic [PIX_W-1:0] max_s1, min_s1, d_s1;
	logic [PIX_W-1:0] r_s1, g_s1, b_s1;
	sector_t          sec_s1;
	logic             vld_s1;

	// stage 2: divider operands
	div_req_t req_s2;
	logic     vld_s2;

	logic adv_s1, adv_s2, div_ready;
	hsv_t res;

	logic [PIX_W-1:0] mx, mn;
	sector_t          sec;

	always_comb begin
		mx = pix_in.blue;
		mn = pix_in.blue;
		if (pix_in.green > mx) mx = pix_in.green;
		if (pix_in.red > mx) mx = pix_in.red;
		if (pix_in.green < mn) mn = pix_in.green;
		if (pix_in.red < mn) mn = pix_in.red;
		if (mx == pix_in.red) begin
			sec = SEC_RED;
		end else if (mx == pix_in.green) begin
			sec = SEC_GREEN;
		end else begin
			sec = SEC_BLUE;
		end
	end

	assign adv_s2       = !vld_s2 || div_ready;
	assign adv_s1       = !vld_s1 || adv_s2;
	assign pix_in.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			max_s1 <= mx;
			min_s1 <= mn;
			d_s1   <= mx - mn;
			r_s1   <= pix_in.red;
			g_s1   <= pix_in.green;
			b_s1   <= pix_in.blue;
			sec_s1 <= sec;
		end
	end

	// hue numerator m, wrapped into 0..6d-1
	logic signed [HUE_MW-1:0] m_raw, m_wrap;
	logic        [HUE_DW-1:0] six_d, m_u;
	div_req_t                 req;

	always_comb begin
		six_d = {1'b0, d_s1, 2'b00} + {2'b00, d_s1, 1'b0};
		case (sec_s1)
			SEC_RED:   m_raw = $signed({4'b0, g_s1}) - $signed({4'b0, b_s1});
			SEC_GREEN: m_raw = $signed({3'b0, d_s1, 1'b0}) + $signed({4'b0, b_s1})
			                   - $signed({4'b0, r_s1});
			SEC_BLUE:  m_raw = $signed({2'b0, d_s1, 2'b00}) + $signed({4'b0, r_s1})
			                   - $signed({4'b0, g_s1});
			default:   m_raw = '0;
		endcase
		m_wrap = m_raw[HUE_MW-1] ? m_raw + $signed({1'b0, six_d}) : m_raw;
		m_u    = m_wrap[HUE_DW-1:0];

		req.num_hue = {m_u, 8'b0} - {8'b0, m_u};
		req.den_hue = (d_s1 == '0) ? HUE_DW'(1) : six_d;
		req.num_sat = {d_s1, 8'b0} - {8'b0, d_s1};
		req.den_sat = (max_s1 == '0) ? PIX_W'(1) : max_s1;
		req.bright  = max_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			req_s2 <= req;
		end
	end

	rth_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (vld_s2),
		.req_ready (div_ready),
		.req       (req_s2),
		.res_valid (pix_out.valid),
		.res_ready (pix_out.ready),
		.res       (res)
	);

	assign pix_out.hue        = res.hue;
	assign pix_out.saturation = res.saturation;
	assign pix_out.brightness = res.brightness;

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (min_s1 <= max_s1) && (d_s1 == max_s1 - min_s1))
		else $error("stage 1 range inconsistent");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && (pix_out.brightness == '0)
		|-> (pix_out.saturation == '0) && (pix_out.hue == '0))
		else $error("black pixel with nonzero hue or saturation");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid |-> (pix_out.hue != 8'hFF))
		else $error("hue reached 255");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> !m_wrap[HUE_MW-1] && ({1'b0, m_u} <= {1'b0, six_d}))
		else $error("hue numerator outside its range");

endmodule
